// ===== design/lsvp_pkg.sv =====
// ----------------------------------------------------------------------------
// lsvp_pkg
// Shared types and defaults for the lifo stack with value purge.
// ----------------------------------------------------------------------------
`default_nettype none

package lsvp_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int WORD_WIDTH_DEF = 32;

  typedef enum logic [1:0] {
    CMD_PUSH  = 2'd0,
    CMD_POP   = 2'd1,
    CMD_PEEK  = 2'd2,
    CMD_PURGE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_READ = 2'd1,
    S_SCAN = 2'd2,
    S_EMIT = 2'd3
  } state_t;

endpackage

`default_nettype wire

// ===== design/lifo_stack_with_value_purge.sv =====
// ----------------------------------------------------------------------------
// lifo_stack_with_value_purge
// Bounded lifo stack of unsigned words with push, pop, peek and value purge.
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)               | tuser
//  in_     | in  | value                            | cmd
//  out_    | out | data, occupancy                  | status
//
//  push emits directly; pop and peek pass a registered memory read;
//  purge scans the stored entries, one through the compare unit per
//  cycle. in_tready is high only while the sequencer is idle. a result
//  sits in the output register; a stall there holds the next result in
//  the sequencer. synchronous active-low reset empties the stack.
// ----------------------------------------------------------------------------
`default_nettype none

module lifo_stack_with_value_purge #(
  parameter int DEPTH      = lsvp_pkg::DEPTH_DEF,
  parameter int WORD_WIDTH = lsvp_pkg::WORD_WIDTH_DEF,
  localparam int AW        = $clog2(DEPTH),
  localparam int LW        = $clog2(DEPTH + 1),
  localparam int IN_DW     = ((WORD_WIDTH + 7) / 8) * 8,
  localparam int OUT_DW    = ((WORD_WIDTH + LW + 7) / 8) * 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [IN_DW-1:0]  in_tdata,   // value
  input  wire logic [1:0]        in_tuser,   // cmd
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic      [OUT_DW-1:0] out_tdata,  // data, occupancy
  output logic      [1:0]        out_tuser   // status
);

  logic                  emit;
  logic                  slot_free;
  logic                  load;
  lsvp_pkg::status_t     res_status;
  logic [WORD_WIDTH-1:0] res_data;
  logic [LW-1:0]         res_occ;

  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [WORD_WIDTH-1:0] mem_wdata;
  logic [AW-1:0]         mem_raddr;
  logic [WORD_WIDTH-1:0] mem_rdata;

  logic                  out_valid_r,  out_valid_nxt;
  lsvp_pkg::status_t     out_status_r;
  logic [WORD_WIDTH-1:0] out_data_r;
  logic [LW-1:0]         out_occ_r;

  lsvp_ctrl #(
    .DEPTH      (DEPTH),
    .WORD_WIDTH (WORD_WIDTH)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_cmd     (in_tuser),
    .in_value   (in_tdata[WORD_WIDTH-1:0]),
    .slot_free  (slot_free),
    .emit       (emit),
    .res_status (res_status),
    .res_data   (res_data),
    .res_occ    (res_occ),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata)
  );

  lsvp_ram #(
    .DEPTH      (DEPTH),
    .WORD_WIDTH (WORD_WIDTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // output register frees up in the same cycle its transaction completes
  assign slot_free     = !out_valid_r || out_tready;
  assign load          = emit && slot_free;
  assign out_valid_nxt = load || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_status_r <= res_status;
      out_data_r   <= res_data;
      out_occ_r    <= res_occ;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = OUT_DW'({out_occ_r, out_data_r});

endmodule

`default_nettype wire

// ===== design/lsvp_ram.sv =====
// ----------------------------------------------------------------------------
// lsvp_ram
// Stack storage: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lsvp_ram #(
  parameter int DEPTH      = lsvp_pkg::DEPTH_DEF,
  parameter int WORD_WIDTH = lsvp_pkg::WORD_WIDTH_DEF,
  localparam int AW        = $clog2(DEPTH)
) (
  input  wire logic                  clk,
  input  wire logic                  we,
  input  wire logic [AW-1:0]         waddr,
  input  wire logic [WORD_WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]         raddr,
  output logic      [WORD_WIDTH-1:0] rdata
);

  logic [WORD_WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== design/lsvp_ctrl.sv =====
// ----------------------------------------------------------------------------
// lsvp_ctrl
// Command sequencer with the shared compare unit used by the purge walk.
// ----------------------------------------------------------------------------
`default_nettype none

module lsvp_ctrl #(
  parameter int DEPTH      = lsvp_pkg::DEPTH_DEF,
  parameter int WORD_WIDTH = lsvp_pkg::WORD_WIDTH_DEF,
  localparam int AW        = $clog2(DEPTH),
  localparam int LW        = $clog2(DEPTH + 1)
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [1:0]            in_cmd,
  input  wire logic [WORD_WIDTH-1:0] in_value,
  input  wire logic                  slot_free,
  output logic                       emit,
  output lsvp_pkg::status_t          res_status,
  output logic      [WORD_WIDTH-1:0] res_data,
  output logic      [LW-1:0]         res_occ,
  output logic                       mem_we,
  output logic      [AW-1:0]         mem_waddr,
  output logic      [WORD_WIDTH-1:0] mem_wdata,
  output logic      [AW-1:0]         mem_raddr,
  input  wire logic [WORD_WIDTH-1:0] mem_rdata
);

  lsvp_pkg::state_t      state_r,  state_nxt;
  lsvp_pkg::status_t     status_r, status_nxt;
  logic [LW-1:0]         level_r,  level_nxt;
  logic [AW-1:0]         rd_r,     rd_nxt;
  logic [LW-1:0]         wr_r,     wr_nxt;
  logic [WORD_WIDTH-1:0] victim_r, victim_nxt;
  logic [WORD_WIDTH-1:0] data_r,   data_nxt;

  logic [LW-1:0] lvl_m1;
  logic [LW-1:0] rd_ext;
  logic [LW-1:0] wr_cnt;
  logic          keep;

  assign lvl_m1 = level_r - LW'(1);
  assign rd_ext = LW'(rd_r) + LW'(1);
  // shared compare unit: one stored entry per cycle during a purge
  assign keep   = (mem_rdata != victim_r);
  assign wr_cnt = wr_r + LW'(keep);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lsvp_pkg::S_IDLE;
      level_r <= '0;
    end else begin
      state_r <= state_nxt;
      level_r <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    rd_r     <= rd_nxt;
    wr_r     <= wr_nxt;
    victim_r <= victim_nxt;
    data_r   <= data_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    status_nxt = status_r;
    level_nxt  = level_r;
    rd_nxt     = rd_r;
    wr_nxt     = wr_r;
    victim_nxt = victim_r;
    data_nxt   = data_r;
    in_ready   = 1'b0;
    emit       = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = level_r[AW-1:0];
    mem_wdata  = in_value;
    mem_raddr  = lvl_m1[AW-1:0];

    case (state_r)
      lsvp_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          status_nxt = lsvp_pkg::ST_DONE;
          data_nxt   = '0;
          state_nxt  = lsvp_pkg::S_EMIT;
          case (lsvp_pkg::cmd_t'(in_cmd))
            lsvp_pkg::CMD_PUSH: begin
              if (level_r == LW'(DEPTH)) begin
                status_nxt = lsvp_pkg::ST_FULL;
              end else begin
                mem_we    = 1'b1;
                level_nxt = level_r + LW'(1);
              end
            end
            lsvp_pkg::CMD_POP: begin
              if (level_r == '0) begin
                status_nxt = lsvp_pkg::ST_EMPTY;
              end else begin
                level_nxt = lvl_m1;
                state_nxt = lsvp_pkg::S_READ;
              end
            end
            lsvp_pkg::CMD_PEEK: begin
              if (level_r == '0) begin
                status_nxt = lsvp_pkg::ST_EMPTY;
              end else begin
                state_nxt = lsvp_pkg::S_READ;
              end
            end
            lsvp_pkg::CMD_PURGE: begin
              if (level_r != '0) begin
                victim_nxt = in_value;
                rd_nxt     = '0;
                wr_nxt     = '0;
                mem_raddr  = '0;
                state_nxt  = lsvp_pkg::S_SCAN;
              end
            end
            default: begin
              state_nxt = lsvp_pkg::S_EMIT;
            end
          endcase
        end
      end

      lsvp_pkg::S_READ: begin
        data_nxt  = mem_rdata;
        state_nxt = lsvp_pkg::S_EMIT;
      end

      lsvp_pkg::S_SCAN: begin
        // survivors are compacted downward, write index never passes read index
        if (keep) begin
          mem_we    = 1'b1;
          mem_waddr = wr_r[AW-1:0];
          mem_wdata = mem_rdata;
        end
        if (rd_ext == level_r) begin
          level_nxt = wr_cnt;
          state_nxt = lsvp_pkg::S_EMIT;
        end else begin
          rd_nxt    = rd_r + AW'(1);
          wr_nxt    = wr_cnt;
          mem_raddr = rd_r + AW'(1);
        end
      end

      lsvp_pkg::S_EMIT: begin
        emit = 1'b1;
        if (slot_free) begin
          state_nxt = lsvp_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = lsvp_pkg::S_IDLE;
      end
    endcase
  end

  assign res_status = status_r;
  assign res_data   = data_r;
  assign res_occ    = level_r;

endmodule

`default_nettype wire

// ===== design/lsvp_checker.sv =====
// ----------------------------------------------------------------------------
// lsvp_checker
// Port-level checks for the lifo stack with value purge, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module lsvp_checker #(
  parameter int DEPTH      = lsvp_pkg::DEPTH_DEF,
  parameter int WORD_WIDTH = lsvp_pkg::WORD_WIDTH_DEF,
  localparam int LW        = $clog2(DEPTH + 1),
  localparam int OUT_DW    = ((WORD_WIDTH + LW + 7) / 8) * 8
) (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_tvalid,
  input wire logic              in_tready,
  input wire logic              out_tvalid,
  input wire logic              out_tready,
  input wire logic [OUT_DW-1:0] out_tdata,
  input wire logic [1:0]        out_tuser
);

  logic [LW-1:0]         occ;
  logic [WORD_WIDTH-1:0] data;

  assign occ  = out_tdata[WORD_WIDTH +: LW];
  assign data = out_tdata[WORD_WIDTH-1:0];

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // in_tready drops once a command is accepted
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("accepted a transaction right after another");

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> occ <= LW'(DEPTH))
    else $error("occupancy above depth");

  // refused commands return zero data and never a full stack on empty refusal
  a_refused_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != lsvp_pkg::ST_DONE |-> data == '0 &&
      ((out_tuser == lsvp_pkg::ST_EMPTY && occ == '0) ||
       (out_tuser == lsvp_pkg::ST_FULL && occ == LW'(DEPTH))))
    else $error("refusal inconsistent with occupancy");

endmodule

bind lifo_stack_with_value_purge lsvp_checker #(
  .DEPTH      (DEPTH),
  .WORD_WIDTH (WORD_WIDTH)
) u_lsvp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire
